@@ rtl/shp_pkg.sv @@
package shp_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int TIMER_WIDTH    = 16;
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int FRAC_WIDTH     = 17;
    localparam int ACT_STEPS      = 5;

    localparam logic [31:0] POS_MAX32 = 32'((64'd1 << POSITION_WIDTH) - 64'd1);
    localparam logic [31:0] TMR_MAX32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [FRAC_WIDTH-1:0] FRAC_FULL = FRAC_WIDTH'(65536);

    typedef logic [POSITION_WIDTH-1:0] t_pos;
    typedef logic [TIMER_WIDTH-1:0]    t_tmr;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_HOME_SETUP = 4'd1,
        PH_HOME_HIGH  = 4'd2,
        PH_HOME_GAP   = 4'd3,
        PH_OFS_SETUP  = 4'd4,
        PH_OFS_HIGH   = 4'd5,
        PH_OFS_GAP    = 4'd6,
        PH_MOV_SETUP  = 4'd7,
        PH_MOV_HIGH   = 4'd8,
        PH_MOV_GAP    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_HOME_DECIDE,
        ACT_BEGIN_OFS,
        ACT_BEGIN_MOV,
        ACT_DECIDE,
        ACT_TARGET
    } t_act;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_PULSE_HIGH  = 3'd0,
        CFG_PULSE_GAP   = 3'd1,
        CFG_DIR_SETUP   = 3'd2,
        CFG_HOME_LIMIT  = 3'd3,
        CFG_PEDAL_OFS   = 3'd4,
        CFG_FULL_TRAVEL = 3'd5,
        CFG_FWD_LEVEL   = 3'd6,
        CFG_LIMIT_LOW   = 3'd7
    } t_cfg_idx;

    function automatic t_pos count_sat(input logic [31:0] v);
        t_pos r;
        if (v > POS_MAX32) begin
            r = POSITION_WIDTH'(POS_MAX32);
        end else begin
            r = POSITION_WIDTH'(v);
        end
        return r;
    endfunction

    function automatic t_tmr timer_load(input logic [CFG_WIDTH-1:0] v, input logic at_least_one);
        logic [31:0] x;
        x = 32'(v);
        if (x > TMR_MAX32) begin
            x = TMR_MAX32;
        end
        if (at_least_one && x == 32'd0) begin
            x = 32'd1;
        end
        return TIMER_WIDTH'(x);
    endfunction

endpackage

@@ rtl/stepper_homing_positioner.sv @@
// Stepper homing positioner for a brake actuator with a limit switch at the
// released end. Every input beat on s_axis is one time tick carrying
// command_valid, brake_fraction and the sampled limit switch level. Every
// accepted beat yields exactly one output beat on m_axis with step and
// direction pin levels, position and status (homed, busy, home failed).
// A command taken while idle homes the motor if needed (reverse steps until
// the limit is seen, bounded by home_step_limit), steps forward by the pedal
// offset, then moves to offset + fraction * span. Commands while busy are
// dropped. A beat's result is on m_axis in the cycle after acceptance.
// Throughput: one beat per cycle while m_axis is ready; the whole tick
// update (timers, step sequencer, target multiply and compare) sits between
// the state registers. s_axis_tready is high whenever the output register
// is empty or being drained, so a stalled receiver holds one result and
// stalls the input. The user must write configuration only while idle;
// the block has no check. It goes through i_cfg_we/i_cfg_addr/i_cfg_data.
// Reset (synchronous, active low) loads the default register values, returns
// to idle, unhomed, at position zero, with no output beat pending.
module stepper_homing_positioner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] command_valid, [17:1] brake_fraction, [18] limit_level
    input  logic [23:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] step_level, [1] dir_level, [17:2] position, [18] is_homed,
    // [19] busy_res, [20] home_failed
    output logic [23:0]                       m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [shp_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [shp_pkg::CFG_WIDTH-1:0]     i_cfg_data
);

    logic [shp_pkg::CFG_WIDTH-1:0] r_pulse_high, r_pulse_gap, r_dir_setup;
    logic [shp_pkg::CFG_WIDTH-1:0] r_home_limit, r_pedal_ofs, r_full_travel;
    logic r_fwd_level, r_limit_low;

    shp_pkg::t_phase r_phase, n_phase;
    shp_pkg::t_pos   r_pos, n_pos;
    shp_pkg::t_tmr   r_tmr, n_tmr;
    shp_pkg::t_pos   r_rem, n_rem;
    logic            r_homed, n_homed;
    logic            r_fwd, n_fwd;
    logic            r_failed, n_failed;
    logic [shp_pkg::FRAC_WIDTH-1:0] r_lfrac, n_lfrac;

    logic        r_out_valid;
    logic [23:0] r_out_data, n_out_data;

    logic                           in_accept;
    logic                           in_cmd;
    logic [shp_pkg::FRAC_WIDTH-1:0] in_frac;
    logic                           in_hit;
    logic [shp_pkg::FRAC_WIDTH-1:0] frac_clamped;
    logic [shp_pkg::FRAC_WIDTH-1:0] eff_frac;
    logic [shp_pkg::CFG_WIDTH-1:0]  span;
    logic [32:0]                    prod;
    logic [16:0]                    target17;
    logic [31:0]                    tgt32;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_cmd  = s_axis_tdata[0];
    assign in_frac = s_axis_tdata[17:1];
    assign in_hit  = s_axis_tdata[18] ^ r_limit_low;

    // target = offset + floor(fraction * span / 65536)
    assign frac_clamped = (in_frac > shp_pkg::FRAC_FULL) ? shp_pkg::FRAC_FULL : in_frac;
    assign eff_frac = (r_phase == shp_pkg::PH_IDLE && in_cmd) ? frac_clamped : r_lfrac;
    assign span     = (r_full_travel > r_pedal_ofs) ? (r_full_travel - r_pedal_ofs) : '0;
    assign prod     = 33'(eff_frac) * 33'(span);
    assign target17 = 17'(r_pedal_ofs) + prod[32:16];
    assign tgt32    = 32'(target17);

    always_comb begin : next_state
        shp_pkg::t_act cur;
        shp_pkg::t_act act;
        logic          expired;
        logic          ofs;
        logic          stop;
        logic [31:0]   pos32;

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_tmr    = r_tmr;
        n_rem    = r_rem;
        n_homed  = r_homed;
        n_fwd    = r_fwd;
        n_failed = r_failed;
        n_lfrac  = r_lfrac;
        act      = shp_pkg::ACT_NONE;
        expired  = 1'b0;
        ofs      = 1'b0;
        stop     = 1'b0;
        pos32    = '0;

        if (n_phase != shp_pkg::PH_IDLE) begin
            expired = (n_tmr <= shp_pkg::t_tmr'(1));
            n_tmr   = expired ? '0 : n_tmr - shp_pkg::t_tmr'(1);
        end

        case (r_phase)
            shp_pkg::PH_IDLE: begin
                if (in_cmd) begin
                    n_lfrac  = frac_clamped;
                    n_failed = 1'b0;
                    if (n_homed) begin
                        act = shp_pkg::ACT_TARGET;
                    end else begin
                        n_fwd   = 1'b0;
                        n_rem   = shp_pkg::count_sat(32'(r_home_limit));
                        n_phase = shp_pkg::PH_HOME_SETUP;
                        n_tmr   = shp_pkg::timer_load(r_dir_setup, 1'b0);
                        if (n_tmr == '0) begin
                            act = shp_pkg::ACT_HOME_DECIDE;
                        end
                    end
                end
            end
            shp_pkg::PH_HOME_SETUP, shp_pkg::PH_HOME_GAP: begin
                if (expired) begin
                    act = shp_pkg::ACT_HOME_DECIDE;
                end
            end
            shp_pkg::PH_HOME_HIGH: begin
                if (expired) begin
                    n_phase = shp_pkg::PH_HOME_GAP;
                    n_tmr   = shp_pkg::timer_load(r_pulse_gap, 1'b1);
                end
            end
            shp_pkg::PH_OFS_HIGH: begin
                if (expired) begin
                    n_phase = shp_pkg::PH_OFS_GAP;
                    n_tmr   = shp_pkg::timer_load(r_pulse_gap, 1'b1);
                end
            end
            shp_pkg::PH_MOV_HIGH: begin
                if (expired) begin
                    n_phase = shp_pkg::PH_MOV_GAP;
                    n_tmr   = shp_pkg::timer_load(r_pulse_gap, 1'b1);
                end
            end
            shp_pkg::PH_OFS_SETUP, shp_pkg::PH_MOV_SETUP: begin
                if (expired) begin
                    act = shp_pkg::ACT_DECIDE;
                end
            end
            shp_pkg::PH_OFS_GAP, shp_pkg::PH_MOV_GAP: begin
                if (expired) begin
                    if (n_fwd) begin
                        if (n_pos != '1) begin
                            n_pos = n_pos + shp_pkg::t_pos'(1);
                        end
                    end else if (n_pos != '0) begin
                        n_pos = n_pos - shp_pkg::t_pos'(1);
                    end
                    act = shp_pkg::ACT_DECIDE;
                end
            end
            default: begin
                n_phase = shp_pkg::PH_IDLE;
                n_tmr   = '0;
            end
        endcase

        // follow-on actions resolved within the same tick
        for (int k = 0; k < shp_pkg::ACT_STEPS; k++) begin
            cur = act;
            act = shp_pkg::ACT_NONE;
            case (cur)
                shp_pkg::ACT_HOME_DECIDE: begin
                    if (n_rem == '0) begin
                        n_homed  = 1'b0;
                        n_failed = 1'b1;
                        n_phase  = shp_pkg::PH_IDLE;
                    end else if (in_hit) begin
                        n_pos = '0;
                        n_rem = shp_pkg::count_sat(32'(r_pedal_ofs));
                        act   = shp_pkg::ACT_BEGIN_OFS;
                    end else begin
                        n_rem   = n_rem - shp_pkg::t_pos'(1);
                        n_phase = shp_pkg::PH_HOME_HIGH;
                        n_tmr   = shp_pkg::timer_load(r_pulse_high, 1'b1);
                    end
                end
                shp_pkg::ACT_BEGIN_OFS, shp_pkg::ACT_BEGIN_MOV: begin
                    ofs = (cur == shp_pkg::ACT_BEGIN_OFS);
                    if (n_rem == '0) begin
                        if (ofs) begin
                            n_homed = 1'b1;
                            act     = shp_pkg::ACT_TARGET;
                        end else begin
                            n_phase = shp_pkg::PH_IDLE;
                        end
                    end else begin
                        if (ofs) begin
                            n_fwd = 1'b1;
                        end
                        n_phase = ofs ? shp_pkg::PH_OFS_SETUP : shp_pkg::PH_MOV_SETUP;
                        n_tmr   = shp_pkg::timer_load(r_dir_setup, 1'b0);
                        if (n_tmr == '0) begin
                            act = shp_pkg::ACT_DECIDE;
                        end
                    end
                end
                shp_pkg::ACT_DECIDE: begin
                    ofs  = n_phase inside {shp_pkg::PH_OFS_SETUP, shp_pkg::PH_OFS_HIGH,
                                           shp_pkg::PH_OFS_GAP};
                    stop = (n_rem == '0);
                    if (!stop && !n_fwd && in_hit) begin
                        n_pos = '0;
                        stop  = 1'b1;
                    end
                    if (stop) begin
                        if (ofs) begin
                            n_homed = 1'b1;
                            act     = shp_pkg::ACT_TARGET;
                        end else begin
                            n_phase = shp_pkg::PH_IDLE;
                        end
                    end else begin
                        n_rem   = n_rem - shp_pkg::t_pos'(1);
                        n_phase = ofs ? shp_pkg::PH_OFS_HIGH : shp_pkg::PH_MOV_HIGH;
                        n_tmr   = shp_pkg::timer_load(r_pulse_high, 1'b1);
                    end
                end
                shp_pkg::ACT_TARGET: begin
                    pos32 = 32'(n_pos);
                    if (tgt32 > pos32) begin
                        n_fwd = 1'b1;
                        n_rem = shp_pkg::count_sat(tgt32 - pos32);
                        act   = shp_pkg::ACT_BEGIN_MOV;
                    end else if (tgt32 < pos32) begin
                        n_fwd = 1'b0;
                        n_rem = shp_pkg::count_sat(pos32 - tgt32);
                        act   = shp_pkg::ACT_BEGIN_MOV;
                    end else begin
                        n_phase = shp_pkg::PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin : outputs
        n_out_data        = '0;
        n_out_data[0]     = (n_phase == shp_pkg::PH_HOME_HIGH) ||
                            (n_phase == shp_pkg::PH_OFS_HIGH)  ||
                            (n_phase == shp_pkg::PH_MOV_HIGH);
        n_out_data[1]     = n_fwd ? r_fwd_level : ~r_fwd_level;
        n_out_data[17:2]  = 16'(n_pos);
        n_out_data[18]    = n_homed;
        n_out_data[19]    = (n_phase != shp_pkg::PH_IDLE);
        n_out_data[20]    = n_failed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_high  <= 16'd10;
            r_pulse_gap   <= 16'd10;
            r_dir_setup   <= 16'd5;
            r_home_limit  <= 16'd4000;
            r_pedal_ofs   <= 16'd200;
            r_full_travel <= 16'd2000;
            r_fwd_level   <= 1'b1;
            r_limit_low   <= 1'b1;
        end else if (i_cfg_we) begin
            case (shp_pkg::t_cfg_idx'(i_cfg_addr))
                shp_pkg::CFG_PULSE_HIGH:  r_pulse_high  <= i_cfg_data;
                shp_pkg::CFG_PULSE_GAP:   r_pulse_gap   <= i_cfg_data;
                shp_pkg::CFG_DIR_SETUP:   r_dir_setup   <= i_cfg_data;
                shp_pkg::CFG_HOME_LIMIT:  r_home_limit  <= i_cfg_data;
                shp_pkg::CFG_PEDAL_OFS:   r_pedal_ofs   <= i_cfg_data;
                shp_pkg::CFG_FULL_TRAVEL: r_full_travel <= i_cfg_data;
                shp_pkg::CFG_FWD_LEVEL:   r_fwd_level   <= i_cfg_data[0];
                shp_pkg::CFG_LIMIT_LOW:   r_limit_low   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= shp_pkg::PH_IDLE;
            r_pos    <= '0;
            r_tmr    <= '0;
            r_rem    <= '0;
            r_homed  <= 1'b0;
            r_fwd    <= 1'b0;
            r_failed <= 1'b0;
            r_lfrac  <= '0;
        end else if (in_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_tmr    <= n_tmr;
            r_rem    <= n_rem;
            r_homed  <= n_homed;
            r_fwd    <= n_fwd;
            r_failed <= n_failed;
            r_lfrac  <= n_lfrac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef ASSERT_OFF
    a_homed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_homed |=> r_homed)
        else $error("homed flag dropped");

    a_homed_failed_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_homed && r_failed))
        else $error("homed and home failed both set");

    a_idle_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == shp_pkg::PH_IDLE && !in_cmd) |=>
        (r_phase == shp_pkg::PH_IDLE && $stable(r_pos) && $stable(r_homed)))
        else $error("idle tick without command changed state");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> r_out_data[19])
        else $error("step pulse reported while not busy");
`endif

endmodule
